// ===== hdl/jmss_pkg.sv =====
// shared constants and types of the jpeg metadata segment stripper
`default_nettype none

package jmss_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned NUM_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  localparam logic [BYTE_W-1:0] MK_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] MK_SOI    = 8'hD8;
  localparam logic [BYTE_W-1:0] MK_EOI    = 8'hD9;
  localparam logic [BYTE_W-1:0] MK_SOS    = 8'hDA;
  localparam logic [BYTE_W-1:0] MK_APP0   = 8'hE0;
  localparam logic [BYTE_W-1:0] MK_APP1   = 8'hE1;
  localparam logic [BYTE_W-1:0] MK_APP3   = 8'hE3;
  localparam logic [BYTE_W-1:0] MK_APPF   = 8'hEF;
  localparam logic [BYTE_W-1:0] MK_COM    = 8'hFE;

  // results of one input word, handed from the parser to the result buffer
  typedef struct packed {
    logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
    logic [NUM_W-1:0]               num;
    logic                           has_byte;
    logic                           last;
    logic                           status;
    logic [CNT_W-1:0]               removed;
  } step_t;

endpackage

`default_nettype wire

// ===== hdl/jmss_if.sv =====
// stream channel interfaces of the jpeg metadata segment stripper
`default_nettype none

interface jmss_in_if;
  logic                       valid;
  logic                       ready;
  logic [jmss_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface jmss_out_if;
  logic                        valid;
  logic                        ready;
  logic [jmss_pkg::BYTE_W-1:0] out_byte;
  logic                        has_byte;
  logic                        out_last;
  logic                        status;
  logic [jmss_pkg::CNT_W-1:0]  removed_count;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  output status, output removed_count, input ready);
  modport sink (input valid, input out_byte, input has_byte, input out_last,
                input status, input removed_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/jmss_parser.sv =====
// marker parser: state registers and per-word result generation
`default_nettype none

module jmss_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [jmss_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                        last_i,
  output jmss_pkg::step_t                  step_o
);
  import jmss_pkg::*;

  typedef enum logic [2:0] {
    PH_START0   = 3'd0,
    PH_START1   = 3'd1,
    PH_HEADER   = 3'd2,
    PH_BODY     = 3'd3,
    PH_PASS     = 3'd4,
    PH_DONE     = 3'd5,
    PH_ERROR    = 3'd6,
    PH_BODY_SOS = 3'd7
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [3:0][BYTE_W-1:0]  win_q, win_d;
  logic [1:0]              fill_q, fill_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic                    keep_q, keep_d;
  logic [CNT_W-1:0]        drop_q, drop_d;

  logic [BYTE_W-1:0]          w0, w1, w2, w3;
  logic [CNT_W-1:0]           seglen;
  logic [CNT_W-1:0]           rem_dec;
  logic                       meta;
  logic                       err;
  logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
  logic [NUM_W-1:0]           num;

  assign w0      = win_q[0];
  assign w1      = win_q[1];
  assign w2      = win_q[2];
  assign w3      = byte_i;
  assign seglen  = {w2, w3};
  assign rem_dec = (rem_q != '0) ? rem_q - CNT_W'(1) : rem_q;
  assign meta    = (w1 == MK_APP0) || (w1 == MK_APP1) || (w1 == MK_COM) ||
                   ((w1 >= MK_APP3) && (w1 <= MK_APPF));

  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    fill_d  = fill_q;
    rem_d   = rem_q;
    keep_d  = keep_q;
    drop_d  = drop_q;
    bytes   = '0;
    num     = '0;
    unique case (phase_q)
      PH_START0: begin
        phase_d = (byte_i == MK_PREFIX) ? PH_START1 : PH_ERROR;
      end
      PH_START1: begin
        if (byte_i == MK_SOI) begin
          bytes[0] = MK_PREFIX;
          bytes[1] = MK_SOI;
          num      = NUM_W'(2);
          phase_d  = PH_HEADER;
          fill_d   = '0;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_HEADER: begin
        win_d[fill_q] = byte_i;
        fill_d        = fill_q + 2'd1;
        if (fill_q == 2'd3) begin
          if (w0 != MK_PREFIX) begin
            bytes   = {w3, w2, w1, w0};
            num     = NUM_W'(4);
            fill_d  = '0;
            phase_d = PH_PASS;
          end else if (w1 == MK_EOI) begin
            bytes[0] = w0;
            bytes[1] = w1;
            num      = NUM_W'(2);
            fill_d   = '0;
            phase_d  = PH_DONE;
          end else if (w1 == MK_SOI) begin
            bytes[0] = w0;
            bytes[1] = w1;
            num      = NUM_W'(2);
            win_d[0] = w2;
            win_d[1] = w3;
            fill_d   = 2'd2;
          end else if (w1 == MK_PREFIX) begin
            win_d[0] = w1;
            win_d[1] = w2;
            win_d[2] = w3;
            fill_d   = 2'd3;
          end else begin
            fill_d = '0;
            if (seglen < CNT_W'(2)) begin
              phase_d = PH_DONE;
            end else begin
              if (meta) begin
                keep_d = 1'b0;
                if (drop_q != '1) begin
                  drop_d = drop_q + CNT_W'(1);
                end
              end else begin
                keep_d = 1'b1;
                bytes  = {w3, w2, w1, w0};
                num    = NUM_W'(4);
              end
              rem_d = seglen - CNT_W'(2);
              if (rem_d == '0) begin
                phase_d = (w1 == MK_SOS) ? PH_PASS : PH_HEADER;
              end else begin
                phase_d = (w1 == MK_SOS) ? PH_BODY_SOS : PH_BODY;
              end
            end
          end
        end
      end
      PH_BODY, PH_BODY_SOS: begin
        if (keep_q) begin
          bytes[0] = byte_i;
          num      = NUM_W'(1);
        end
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = (phase_q == PH_BODY_SOS) ? PH_PASS : PH_HEADER;
          fill_d  = '0;
        end
      end
      PH_PASS: begin
        bytes[0] = byte_i;
        num      = NUM_W'(1);
      end
      PH_DONE, PH_ERROR: begin
      end
    endcase
  end

  assign err = (phase_d == PH_ERROR) || (phase_d == PH_START0) || (phase_d == PH_START1);

  always_comb begin
    step_o.bytes    = bytes;
    step_o.num      = num;
    step_o.has_byte = 1'b1;
    step_o.last     = last_i;
    step_o.status   = last_i & err;
    step_o.removed  = drop_d;
    // closing word with no stream byte
    if (last_i && (num == '0)) begin
      step_o.num      = NUM_W'(1);
      step_o.has_byte = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START0;
      fill_q  <= '0;
      rem_q   <= '0;
      keep_q  <= 1'b0;
      drop_q  <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q <= PH_START0;
        fill_q  <= '0;
        rem_q   <= '0;
        keep_q  <= 1'b0;
        drop_q  <= '0;
      end else begin
        phase_q <= phase_d;
        fill_q  <= fill_d;
        rem_q   <= rem_d;
        keep_q  <= keep_d;
        drop_q  <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jpeg_metadata_segment_stripper_top.sv =====
// top level of the jpeg metadata segment stripper
//
// channel  dir  words                        handshake
// in_i     in   in_byte, in_last             valid/ready
// out_o    out  out_byte, has_byte, out_last,  valid/ready
//               status, removed_count
//
// each input word is parsed in the cycle it is accepted and gives 0 to 4 output
// words, which a four-entry result buffer hands out one per cycle while out_o is ready
// a word giving at most one output word is taken every cycle unless output stalls;
// more words hold the input until the last is out, set by the single output port
// reset is asynchronous and active low; it clears parser state and empties the buffer
// an output stall holds the buffer and, while any word waits, the input
`default_nettype none

module jpeg_metadata_segment_stripper_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jmss_in_if.sink   in_i,
  jmss_out_if.source out_o
);
  import jmss_pkg::*;

  step_t                          step;
  logic                           in_acc;
  logic                           out_acc;
  logic [MAX_RES-1:0][BYTE_W-1:0] bytes_q;
  logic [NUM_W-1:0]               cnt_q;
  logic [IDX_W-1:0]               idx_q;
  logic                           has_q;
  logic                           last_q;
  logic                           status_q;
  logic [CNT_W-1:0]               removed_q;

  assign in_i.ready = (cnt_q == '0) || ((cnt_q == NUM_W'(1)) && out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  jmss_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.in_last),
    .step_o   (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (in_acc) begin
      cnt_q <= step.num;
      idx_q <= '0;
    end else if (out_acc) begin
      cnt_q <= cnt_q - NUM_W'(1);
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bytes_q   <= step.bytes;
      has_q     <= step.has_byte;
      last_q    <= step.last;
      status_q  <= step.status;
      removed_q <= step.removed;
    end
  end

  assign out_o.valid         = (cnt_q != '0);
  assign out_o.out_byte      = bytes_q[idx_q];
  assign out_o.has_byte      = has_q;
  assign out_o.out_last      = last_q && (cnt_q == NUM_W'(1));
  assign out_o.status        = status_q;
  assign out_o.removed_count = removed_q;

endmodule

`default_nettype wire

// ===== dv/tb_jpeg_metadata_segment_stripper_top.sv =====
// self-checking testbench of the jpeg metadata segment stripper, with a parser model
`timescale 1ns / 1ps

module tb_jpeg_metadata_segment_stripper_top;
  import jmss_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RX_HOLD     = 300;
  localparam int unsigned RANDOM_BYTES = 480;

  typedef enum logic [2:0] {
    ST_WANT_FF, ST_WANT_SOI, ST_HEADER, ST_BODY, ST_COPY, ST_STOPPED, ST_BAD, ST_SCAN_BODY
  } parse_st_e;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    bit                hold;
  } src_byte_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              last;
    logic              status;
    logic [CNT_W-1:0]  removed;
  } clean_word_t;

  logic clk_i;
  logic rst_ni;

  jmss_in_if  in_if ();
  jmss_out_if out_if ();

  jpeg_metadata_segment_stripper_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // parser model state
  parse_st_e         ps;
  logic [BYTE_W-1:0] win [4];
  logic [2:0]        fill;
  logic [CNT_W-1:0]  body_left;
  logic              keep;
  logic [CNT_W-1:0]  dropped;

  src_byte_t         byte_q [$];
  clean_word_t       clean_q [$];
  logic [BYTE_W-1:0] file_q [$];

  int unsigned total_bytes;
  int unsigned in_acc_cnt;
  int unsigned in_sent_cnt;
  int unsigned out_acc_cnt;
  int unsigned out_seen;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned tx_wait, tx_run;
  int unsigned rx_wait, rx_run;
  int unsigned rx_hold_left;
  bit          rx_hold_done;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic reset_parser();
    ps        = ST_WANT_FF;
    win       = '{default: '0};
    fill      = '0;
    body_left = '0;
    keep      = 1'b0;
    dropped   = '0;
  endtask

  task automatic strip_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [BYTE_W-1:0] emitted [$];
    logic [CNT_W-1:0]  seg_len;
    logic              bad;
    clean_word_t       w;
    emitted = {};
    case (ps)
      ST_WANT_FF: ps = (b == MK_PREFIX) ? ST_WANT_SOI : ST_BAD;
      ST_WANT_SOI: begin
        if (b == MK_SOI) begin
          emitted.push_back(MK_PREFIX);
          emitted.push_back(MK_SOI);
          ps   = ST_HEADER;
          fill = '0;
        end else begin
          ps = ST_BAD;
        end
      end
      ST_HEADER: begin
        win[fill[1:0]] = b;
        fill = {1'b0, fill[1:0]} + 3'd1;
        if (fill == 3'd4) begin
          if (win[0] != MK_PREFIX) begin
            for (int i = 0; i < 4; i++) emitted.push_back(win[i]);
            fill = '0;
            ps   = ST_COPY;
          end else if (win[1] == MK_EOI) begin
            emitted.push_back(win[0]);
            emitted.push_back(win[1]);
            fill = '0;
            ps   = ST_STOPPED;
          end else if (win[1] == MK_SOI) begin
            emitted.push_back(win[0]);
            emitted.push_back(win[1]);
            win[0] = win[2];
            win[1] = win[3];
            fill   = 3'd2;
          end else if (win[1] == MK_PREFIX) begin
            // fill byte: slide the window by one
            win[0] = win[1];
            win[1] = win[2];
            win[2] = win[3];
            fill   = 3'd3;
          end else begin
            seg_len = {win[2], win[3]};
            fill    = '0;
            if (seg_len < CNT_W'(2)) begin
              ps = ST_STOPPED;
            end else begin
              if (win[1] == MK_APP0 || win[1] == MK_APP1 || win[1] == MK_COM ||
                  (win[1] >= MK_APP3 && win[1] <= MK_APPF)) begin
                keep = 1'b0;
                if (dropped != '1) dropped = dropped + CNT_W'(1);
              end else begin
                keep = 1'b1;
                for (int i = 0; i < 4; i++) emitted.push_back(win[i]);
              end
              body_left = seg_len - CNT_W'(2);
              if (body_left == 0) ps = (win[1] == MK_SOS) ? ST_COPY : ST_HEADER;
              else ps = (win[1] == MK_SOS) ? ST_SCAN_BODY : ST_BODY;
            end
          end
        end
      end
      ST_BODY, ST_SCAN_BODY: begin
        if (keep) emitted.push_back(b);
        if (body_left != 0) body_left = body_left - CNT_W'(1);
        if (body_left == 0) begin
          ps   = (ps == ST_SCAN_BODY) ? ST_COPY : ST_HEADER;
          fill = '0;
        end
      end
      ST_COPY: emitted.push_back(b);
      default: ;
    endcase

    bad = (ps == ST_BAD || ps == ST_WANT_FF || ps == ST_WANT_SOI);
    if (last && emitted.size() == 0) begin
      w = '{data: '0, has: 1'b0, last: 1'b1, status: bad, removed: dropped};
      clean_q.push_back(w);
    end
    foreach (emitted[i]) begin
      w.data    = emitted[i];
      w.has     = 1'b1;
      w.last    = last && (i == emitted.size() - 1);
      w.status  = last && bad;
      w.removed = dropped;
      clean_q.push_back(w);
    end
    if (last) reset_parser();
  endtask

  task automatic flush_file(input bit hold);
    src_byte_t it;
    foreach (file_q[i]) begin
      it.data = file_q[i];
      it.last = (i == file_q.size() - 1);
      it.hold = hold && (i == 0);
      byte_q.push_back(it);
    end
  endtask

  task automatic build_file();
    int unsigned       len;
    int unsigned       nbody;
    logic [BYTE_W-1:0] mk;
    file_q = {};
    // pure noise
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
      return;
    end
    file_q.push_back(MK_PREFIX);
    file_q.push_back(MK_SOI);
    if ($urandom_range(0, 11) == 0) begin
      nbody = $urandom_range(0, 1);
      file_q[nbody] = 8'($urandom);
    end
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0:       mk = MK_APP0;
        1:       mk = MK_APP1;
        2:       mk = 8'($urandom_range(8'hE2, 8'hEF));
        3:       mk = MK_COM;
        4:       mk = 8'($urandom);
        5:       mk = 8'hDB;
        6:       mk = 8'hC4;
        7:       mk = 8'hC0;
        8:       mk = 8'hDD;
        default: mk = MK_SOI;
      endcase
      if ($urandom_range(0, 5) == 0) file_q.push_back(MK_PREFIX);
      if ($urandom_range(0, 15) == 0) file_q.push_back(8'($urandom_range(0, 8'hFE)));
      file_q.push_back(MK_PREFIX);
      file_q.push_back(mk);
      if (mk != MK_SOI && mk != MK_EOI && mk != MK_PREFIX) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(0, 1);
          1:       len = $urandom_range(64, 65535);
          default: len = $urandom_range(2, 7);
        endcase
        file_q.push_back(8'(len >> 8));
        file_q.push_back(8'(len));
        if (len < 2 || len > 7) nbody = $urandom_range(0, 6);
        else nbody = len - 2;
        repeat (nbody) file_q.push_back(8'($urandom));
        // stopped or body running past the end of file
        if (len < 2 || len > 7) return;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      len = $urandom_range(2, 5);
      file_q.push_back(MK_PREFIX);
      file_q.push_back(MK_SOS);
      file_q.push_back(8'h00);
      file_q.push_back(8'(len));
      repeat (len - 2) file_q.push_back(8'($urandom));
      repeat ($urandom_range(0, 8)) file_q.push_back(8'($urandom));
    end
    case ($urandom_range(0, 3))
      0: begin
        file_q.push_back(MK_PREFIX);
        file_q.push_back(MK_EOI);
      end
      1: begin
        file_q.push_back(MK_PREFIX);
        file_q.push_back(MK_EOI);
        repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
      end
      2: ;
      default: begin
        // header window left incomplete
        file_q.push_back(MK_PREFIX);
        if ($urandom_range(0, 1) == 1) file_q.push_back(8'hC4);
      end
    endcase
  endtask

  task automatic draw_gap(inout int unsigned run, output int unsigned gap);
    if (run > 0) begin
      run--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 31) == 0) run = $urandom_range(10, 40);
    end
  endtask

  // input driver
  always @(negedge clk_i) begin : drive_in
    logic      offer;
    src_byte_t it;
    offer = in_if.valid;
    if (rst_ni) begin
      if (offer && in_acc_cnt == in_sent_cnt) begin
        offer = 1'b0;
        draw_gap(tx_run, tx_wait);
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (byte_q.size() != 0 && !(byte_q[0].hold && clean_q.size() != 0)) begin
          it = byte_q.pop_front();
          in_if.in_byte <= it.data;
          in_if.in_last <= it.last;
          offer = 1'b1;
          in_sent_cnt++;
        end
      end
      in_if.valid <= offer;
    end
  end

  // output ready driver
  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (out_acc_cnt != out_seen) begin
        out_seen = out_acc_cnt;
        draw_gap(rx_run, rx_wait);
      end
      if (!rx_hold_done && out_acc_cnt >= 60) begin
        rx_hold_done = 1'b1;
        rx_hold_left = RX_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted input word, check accepted output word
  always @(posedge clk_i) begin : monitor
    clean_word_t w;
    bit          busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        strip_byte(in_if.in_byte, in_if.in_last);
        in_acc_cnt++;
        busy = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        out_acc_cnt++;
        busy = 1'b1;
        if (clean_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d unexpected: got %h/%b/%b/%b/%0d", out_acc_cnt,
                     out_if.out_byte, out_if.has_byte, out_if.out_last, out_if.status,
                     out_if.removed_count);
        end else begin
          w = clean_q.pop_front();
          if (out_if.out_byte !== w.data || out_if.has_byte !== w.has ||
              out_if.out_last !== w.last || out_if.status !== w.status ||
              out_if.removed_count !== w.removed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch (byte/has/last/status/count): exp %h/%b/%b/%b/%0d got %h/%b/%b/%b/%0d",
                       out_acc_cnt, w.data, w.has, w.last, w.status, w.removed,
                       out_if.out_byte, out_if.has_byte, out_if.out_last, out_if.status,
                       out_if.removed_count);
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("tb_jpeg_metadata_segment_stripper_top NOT OK");
    $finish;
  end

  initial begin : main
    int unsigned nfiles;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    in_acc_cnt    = 0;
    in_sent_cnt   = 0;
    out_acc_cnt   = 0;
    out_seen      = 0;
    idle_cycles   = 0;
    mismatches    = 0;
    tx_wait       = 0;
    tx_run        = 0;
    rx_wait       = 0;
    rx_run        = 0;
    rx_hold_left  = 0;
    rx_hold_done  = 1'b0;
    reset_parser();

    // short file, bad second byte
    file_q = '{8'hFF};
    flush_file(1'b0);
    file_q = '{8'hFF, 8'h00};
    flush_file(1'b0);
    // soi in window, com dropped, fill byte, appf with body, sos then copy
    file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD8, 8'hFF, 8'hFE, 8'h00, 8'h02, 8'hFF, 8'hFF,
               8'hEF, 8'h00, 8'h03, 8'h00, 8'hFF, 8'hDA, 8'h00, 8'h02, 8'h7F};
    flush_file(1'b0);
    // eoi with one following byte leaves the header window incomplete
    file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD9, 8'hAA};
    flush_file(1'b0);
    // length below two stops the block
    file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h01, 8'h80};
    flush_file(1'b0);

    nfiles = 0;
    total_bytes = RANDOM_BYTES;
    while (byte_q.size() < total_bytes) begin
      build_file();
      flush_file(nfiles % 8 == 0);
      nfiles++;
    end
    total_bytes = byte_q.size();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (in_acc_cnt != total_bytes) @(negedge clk_i);
    while (clean_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (mismatches == 0 && clean_q.size() == 0) begin
      $display("tb_jpeg_metadata_segment_stripper_top OK");
    end else begin
      $display("tb_jpeg_metadata_segment_stripper_top NOT OK");
    end
    $finish;
  end

endmodule
